// ===== hdl/vira_pkg.sv =====
`default_nettype none
package vira_pkg;

  // Widths of the transaction fields, fixed by the interface.
  localparam int KIND_W   = 1;
  localparam int LEN_W    = 13;
  localparam int OFFOUT_W = 12;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 15;
  localparam int REG_W    = 13;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [REG_W-1:0] REGION_RESET = 13'd4096;
  localparam logic [CNT_W-1:0] COUNT_MAX    = 15'h7FFF;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  // Register index, taken from paddr[2] (registers are 4 bytes apart).
  typedef enum logic {
    REG_REGION = 1'b0,
    REG_NONE   = 1'b1
  } reg_idx_t;

endpackage
`default_nettype wire

// ===== hdl/vira_ram.sv =====
`default_nettype none
module vira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/variable_item_ring_allocator_top.sv =====
`default_nettype none
// Descriptor ring allocator: each input transaction either inserts an item of
// item_size bytes, receiving an offset in the data region, or reads back the
// oldest stored descriptor. A transaction can be accepted in every clock cycle
// while the result side is not stalling. It is taken into the input register
// when accepted, and its result is loaded into the result register when the
// input register advances; the result is offered from there. A stalled
// result holds the input register, and the input stalls only while that
// register cannot move on. The descriptor RAM is read ahead at the next head
// slot, with a bypass for a descriptor written to that slot in the same cycle
// as the read, and the end of the previous item is kept in a register, so no
// transaction waits on the memory. Entries never written since reset read as
// zero through a fill count, so there is no clearing pass. region_bytes is
// written through the APB port at address 0 and should only be changed while
// no transaction is in flight.
module variable_item_ring_allocator_top #(
  parameter int RING_ITEMS       = 16,
  parameter int REGION_MAX_BYTES = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [vira_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [vira_pkg::LEN_W-1:0]    in_item_size,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [vira_pkg::STAT_W-1:0]   out_status,
  output logic      [vira_pkg::OFFOUT_W-1:0] out_data_offset,
  output logic      [vira_pkg::LEN_W-1:0]    out_item_length,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [vira_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [vira_pkg::DATA_W-1:0]   pwdata,
  output logic      [vira_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int SLOT_W = $clog2(RING_ITEMS);
  localparam int FILL_W = $clog2(RING_ITEMS + 1);
  localparam int OFS_W  = $clog2(REGION_MAX_BYTES);
  localparam int LEN_W  = vira_pkg::LEN_W;
  localparam int CNT_W  = vira_pkg::CNT_W;
  localparam int SUM_W  = ((OFS_W > LEN_W) ? OFS_W : LEN_W) + 2;
  localparam int ENT_W  = OFS_W + LEN_W;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_ITEMS - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_ITEMS);
  localparam logic [CNT_W-1:0]  HELD_FULL = CNT_W'(RING_ITEMS);
  localparam logic [SUM_W-1:0]  REGION_CAP = SUM_W'(REGION_MAX_BYTES);

  // configuration
  logic [vira_pkg::REG_W-1:0] region_r;
  logic                       cfg_wr;

  // state
  logic [CNT_W-1:0]  ins_cnt_r, ins_cnt_nxt;
  logic [CNT_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic [SLOT_W-1:0] ins_slot_r, ins_slot_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0]  prev_end_r, prev_end_nxt;

  // input register
  logic                     s1_valid_r;
  vira_pkg::kind_t          s1_kind_r;
  logic [LEN_W-1:0]         s1_size_r;

  // result register
  logic                     out_valid_r;
  vira_pkg::status_t        out_status_r, out_status_nxt;
  logic [vira_pkg::OFFOUT_W-1:0] out_offset_r, out_offset_nxt;
  logic [LEN_W-1:0]         out_length_r, out_length_nxt;

  // head descriptor path
  logic [ENT_W-1:0] ram_rdata;
  logic [ENT_W-1:0] head_fwd_data_r;
  logic             head_fwd_r;
  logic             head_valid_r;
  logic [ENT_W-1:0] head_ent;
  logic [SUM_W-1:0] head_off;
  logic [LEN_W-1:0] head_len;

  logic             advance;
  logic             in_accept;
  logic             ins_commit;
  logic             rd_commit;
  logic [CNT_W-1:0] held;
  logic [SUM_W-1:0] region_used;
  logic [SUM_W-1:0] size_ext;
  logic [SUM_W-1:0] place;
  logic [SUM_W-1:0] end_sum;
  logic             ins_ok;
  logic             ram_we;
  logic [ENT_W-1:0] ram_wdata;

  // ------------------------------------------------------------------
  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (vira_pkg::reg_idx_t'(paddr[2]) == vira_pkg::REG_REGION);

  always_comb begin
    prdata = '0;
    if (vira_pkg::reg_idx_t'(paddr[2]) == vira_pkg::REG_REGION) begin
      prdata = vira_pkg::DATA_W'(region_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= vira_pkg::REGION_RESET;
    end else if (cfg_wr) begin
      region_r <= pwdata[vira_pkg::REG_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // handshake
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // ------------------------------------------------------------------
  // allocation logic
  assign held        = ins_cnt_r - rd_cnt_r;
  assign size_ext    = SUM_W'(s1_size_r);
  assign region_used = (SUM_W'(region_r) > REGION_CAP) ? REGION_CAP : SUM_W'(region_r);
  assign end_sum     = prev_end_r + size_ext;

  assign head_ent = head_fwd_r   ? head_fwd_data_r :
                    head_valid_r ? ram_rdata       : '0;
  assign head_off = SUM_W'(head_ent[ENT_W-1:LEN_W]);
  assign head_len = head_ent[LEN_W-1:0];

  always_comb begin
    ins_ok = 1'b1;
    place  = '0;
    if (held == HELD_FULL) begin
      ins_ok = 1'b0;
    end else if (ins_cnt_r != '0) begin
      if (end_sum < region_used) begin
        place = prev_end_r;
      end else if (!(head_off > size_ext)) begin
        ins_ok = 1'b0;
      end
    end
  end

  assign ins_commit = advance && (s1_kind_r == vira_pkg::KIND_INSERT) && ins_ok;
  assign rd_commit  = advance && (s1_kind_r == vira_pkg::KIND_READ) && (held != '0);

  always_comb begin
    out_status_nxt = vira_pkg::ST_OK;
    out_offset_nxt = '0;
    out_length_nxt = s1_size_r;
    if (s1_kind_r == vira_pkg::KIND_INSERT) begin
      if (ins_ok) begin
        out_offset_nxt = place[vira_pkg::OFFOUT_W-1:0];
      end else begin
        out_status_nxt = vira_pkg::ST_FULL;
      end
    end else if (held == '0) begin
      out_status_nxt = vira_pkg::ST_EMPTY;
      out_length_nxt = '0;
    end else begin
      out_offset_nxt = head_off[vira_pkg::OFFOUT_W-1:0];
      out_length_nxt = head_len;
    end
  end

  // Slots follow the 15-bit counts: they restart at zero when a count wraps.
  always_comb begin
    ins_cnt_nxt  = ins_cnt_r;
    ins_slot_nxt = ins_slot_r;
    fill_nxt     = fill_r;
    prev_end_nxt = prev_end_r;
    if (ins_commit) begin
      ins_cnt_nxt  = ins_cnt_r + 1'b1;
      prev_end_nxt = place + size_ext;
      if (ins_cnt_r == vira_pkg::COUNT_MAX || ins_slot_r == SLOT_LAST) begin
        ins_slot_nxt = '0;
      end else begin
        ins_slot_nxt = ins_slot_r + 1'b1;
      end
      if (fill_r != FILL_FULL) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_comb begin
    rd_cnt_nxt  = rd_cnt_r;
    rd_slot_nxt = rd_slot_r;
    if (rd_commit) begin
      rd_cnt_nxt = rd_cnt_r + 1'b1;
      if (rd_cnt_r == vira_pkg::COUNT_MAX || rd_slot_r == SLOT_LAST) begin
        rd_slot_nxt = '0;
      end else begin
        rd_slot_nxt = rd_slot_r + 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // descriptor memory, read ahead at the next head slot
  assign ram_we    = ins_commit;
  assign ram_wdata = {place[OFS_W-1:0], s1_size_r};

  vira_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RING_ITEMS)
  ) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ins_slot_r),
    .wdata (ram_wdata),
    .raddr (rd_slot_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    head_fwd_data_r <= ram_wdata;
  end

  // ------------------------------------------------------------------
  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_cnt_r    <= '0;
      rd_cnt_r     <= '0;
      ins_slot_r   <= '0;
      rd_slot_r    <= '0;
      fill_r       <= '0;
      prev_end_r   <= '0;
      head_fwd_r   <= 1'b0;
      head_valid_r <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      ins_cnt_r    <= ins_cnt_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      ins_slot_r   <= ins_slot_nxt;
      rd_slot_r    <= rd_slot_nxt;
      fill_r       <= fill_nxt;
      prev_end_r   <= prev_end_nxt;
      head_fwd_r   <= ram_we && (ins_slot_r == rd_slot_nxt);
      head_valid_r <= (FILL_W'(rd_slot_nxt) < fill_nxt);
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r <= vira_pkg::kind_t'(in_kind);
      s1_size_r <= in_item_size;
    end
    if (advance) begin
      out_status_r <= out_status_nxt;
      out_offset_r <= out_offset_nxt;
      out_length_r <= out_length_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_offset = out_offset_r;
  assign out_item_length = out_length_r;

endmodule
`default_nettype wire

// ===== hdl/vira_chk.sv =====
`default_nettype none
module vira_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [vira_pkg::STAT_W-1:0]   out_status,
  input wire logic [vira_pkg::OFFOUT_W-1:0] out_data_offset,
  input wire logic [vira_pkg::LEN_W-1:0]    out_item_length
);

  // Nothing is delivered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_data_offset) && $stable(out_item_length))
    else $error("stalled result changed or was dropped");

  // An empty read reports neither offset nor length.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == vira_pkg::ST_EMPTY |->
      out_data_offset == '0 && out_item_length == '0)
    else $error("empty read carried a descriptor");

  // A refused insert is given no place in the region.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == vira_pkg::ST_FULL |-> out_data_offset == '0)
    else $error("refused insert carried an offset");

  // With no transaction waiting and the result side free, the input is open.
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && !out_valid && !out_stall |=> !in_stall)
    else $error("input stalled with nothing in flight");

endmodule

bind variable_item_ring_allocator_top vira_chk u_vira_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_data_offset (out_data_offset),
  .out_item_length (out_item_length)
);
`default_nettype wire

// ===== tb/sv/tb_variable_item_ring_allocator_top.sv =====
`default_nettype none
module tb_variable_item_ring_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_ITEMS       = 16;
  localparam int REGION_MAX_BYTES = 4096;
  localparam int CYCLE_LIMIT      = 1000000;

  localparam int KIND_W   = vira_pkg::KIND_W;
  localparam int LEN_W    = vira_pkg::LEN_W;
  localparam int OFFOUT_W = vira_pkg::OFFOUT_W;
  localparam int STAT_W   = vira_pkg::STAT_W;
  localparam int CNT_W    = vira_pkg::CNT_W;
  localparam int REG_W    = vira_pkg::REG_W;
  localparam int ADDR_W   = vira_pkg::ADDR_W;
  localparam int DATA_W   = vira_pkg::DATA_W;

  typedef struct packed {
    vira_pkg::status_t     status;
    logic [OFFOUT_W-1:0]   offset;
    logic [LEN_W-1:0]      length;
  } alloc_result_t;

  // Tracks descriptor placement and holds the results still owed by the block.
  class alloc_scoreboard;
    logic [OFFOUT_W-1:0] slot_offset [RING_ITEMS];
    logic [LEN_W-1:0]    slot_length [RING_ITEMS];
    logic [CNT_W-1:0]    inserted;
    logic [CNT_W-1:0]    consumed;
    logic [REG_W-1:0]    region;
    alloc_result_t       expected_alloc [$];
    int                  errors;

    function new();
      foreach (slot_offset[i]) begin
        slot_offset[i] = '0;
        slot_length[i] = '0;
      end
      inserted = '0;
      consumed = '0;
      region   = vira_pkg::REGION_RESET;
      errors   = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function void note_request(vira_pkg::kind_t kind, logic [LEN_W-1:0] size);
      alloc_result_t    res;
      logic [CNT_W-1:0] held;
      logic [CNT_W-1:0] prev_count;
      int               cap, head_slot, tail_slot, tail_end, place, slot;
      bit               granted;
      held       = inserted - consumed;
      prev_count = inserted - 1'b1;
      cap        = (int'(region) > REGION_MAX_BYTES) ? REGION_MAX_BYTES : int'(region);
      head_slot  = int'(consumed) % RING_ITEMS;
      if (kind == vira_pkg::KIND_INSERT) begin
        place   = 0;
        granted = 1'b1;
        if (held == RING_ITEMS) begin
          granted = 1'b0;
        end else if (inserted != 0) begin
          tail_slot = int'(prev_count) % RING_ITEMS;
          tail_end  = int'(slot_offset[tail_slot]) + int'(slot_length[tail_slot]);
          if (tail_end + int'(size) < cap) begin
            place = tail_end;
          end else if (int'(slot_offset[head_slot]) > int'(size)) begin
            // Wrap to the start of the region, behind the oldest descriptor.
            place = 0;
          end else begin
            granted = 1'b0;
          end
        end
        if (granted) begin
          slot = int'(inserted) % RING_ITEMS;
          slot_offset[slot] = place[OFFOUT_W-1:0];
          slot_length[slot] = size;
          inserted = inserted + 1'b1;
          res = '{vira_pkg::ST_OK, place[OFFOUT_W-1:0], size};
        end else begin
          res = '{vira_pkg::ST_FULL, '0, size};
        end
      end else if (held == 0) begin
        res = '{vira_pkg::ST_EMPTY, '0, '0};
      end else begin
        res = '{vira_pkg::ST_OK, slot_offset[head_slot], slot_length[head_slot]};
        consumed = consumed + 1'b1;
      end
      expected_alloc.push_back(res);
    endfunction

    task check_result(logic [STAT_W-1:0] status, logic [OFFOUT_W-1:0] offset,
                      logic [LEN_W-1:0] length);
      alloc_result_t want;
      if (expected_alloc.size() == 0) begin
        report("result transaction with no request outstanding");
      end else begin
        want = expected_alloc.pop_front();
        if (status !== want.status)
          report($sformatf("status %0d, expected %0d", status, want.status));
        if (offset !== want.offset)
          report($sformatf("data_offset %0d, expected %0d", offset, want.offset));
        if (length !== want.length)
          report($sformatf("item_length %0d, expected %0d", length, want.length));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind;
  logic [LEN_W-1:0]    in_item_size;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [OFFOUT_W-1:0] out_data_offset;
  logic [LEN_W-1:0]    out_item_length;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  bit                  steady = 1'b0;
  int                  cycles = 0;
  alloc_scoreboard     sb = new();

  variable_item_ring_allocator_top #(
    .RING_ITEMS       (RING_ITEMS),
    .REGION_MAX_BYTES (REGION_MAX_BYTES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_item_size    (in_item_size),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_data_offset (out_data_offset),
    .out_item_length (out_item_length),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !steady && ($urandom_range(0, 99) < 13);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_data_offset, out_item_length);
  end

  task automatic send(vira_pkg::kind_t kind, logic [LEN_W-1:0] size);
    while (!steady && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_item_size <= size;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, size);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.expected_alloc.size() != 0) @(posedge clk);
  endtask

  // Leaves psel high so that transfers can follow back to back.
  task automatic apb_access(bit is_write, logic [ADDR_W-1:0] addr,
                            logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic set_region(logic [REG_W-1:0] value, bit poke_spare);
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] readback;
    wait_for_results();
    if (poke_spare) apb_access(1'b1, {vira_pkg::REG_NONE, 2'b00}, $urandom(), readback);
    data = $urandom();
    data[REG_W-1:0] = value;
    apb_access(1'b1, {vira_pkg::REG_REGION, 2'b00}, data, readback);
    sb.region = value;
    apb_access(1'b0, {vira_pkg::REG_REGION, 2'b00}, '0, readback);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== {{(DATA_W-REG_W){1'b0}}, value})
      sb.report($sformatf("region_bytes read back as %0d, expected %0d", readback, value));
  endtask

  task automatic run_phase(logic [REG_W-1:0] region_val, int n_items, int insert_pct,
                           bit no_idle);
    int cap, r;
    logic [LEN_W-1:0] size;
    set_region(region_val, 1'b0);
    steady = no_idle;
    cap = (int'(region_val) > REGION_MAX_BYTES) ? REGION_MAX_BYTES : int'(region_val);
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_for_results();
      if ($urandom_range(0, 99) < insert_pct) begin
        r = $urandom_range(0, 99);
        if (r < 8) size = '0;
        else if (r < 14) size = LEN_W'(REGION_MAX_BYTES);
        else if (r < 24) size = LEN_W'($urandom_range(0, REGION_MAX_BYTES));
        else if (r < 34) size = (cap > 3) ? LEN_W'(cap - $urandom_range(0, 3)) : '0;
        else size = LEN_W'($urandom_range(0, cap / 8 + 1));
        send(vira_pkg::KIND_INSERT, size);
      end else begin
        send(vira_pkg::KIND_READ, LEN_W'($urandom_range(0, 8191)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_kind      <= vira_pkg::KIND_INSERT;
    in_item_size <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening sequence at the reset region size: empty reads, the first insert,
    // the largest offset, a wrap to the start and a head check on an empty ring.
    send(vira_pkg::KIND_READ, 13'h1fff);
    send(vira_pkg::KIND_INSERT, 13'd100);
    send(vira_pkg::KIND_INSERT, 13'd4096);
    send(vira_pkg::KIND_INSERT, 13'd3995);
    send(vira_pkg::KIND_INSERT, 13'd0);
    send(vira_pkg::KIND_INSERT, 13'd1);
    send(vira_pkg::KIND_READ, 13'd0);
    send(vira_pkg::KIND_INSERT, 13'd50);
    send(vira_pkg::KIND_INSERT, 13'd60);
    repeat (4) send(vira_pkg::KIND_READ, 13'h0aaa);
    send(vira_pkg::KIND_READ, 13'h1555);
    send(vira_pkg::KIND_INSERT, 13'd4000);

    // A zero-sized region refuses everything once the first insert has gone.
    set_region(13'd0, 1'b1);
    send(vira_pkg::KIND_INSERT, 13'd0);
    send(vira_pkg::KIND_INSERT, 13'd7);
    send(vira_pkg::KIND_READ, 13'd0);

    run_phase(13'h1fff, 250, 70, 1'b1);
    run_phase(13'd100, 250, 55, 1'b0);
    run_phase(13'd4096, 250, 45, 1'b0);
    run_phase(13'd1, 200, 60, 1'b0);
    run_phase(13'd3000, 250, 55, 1'b0);
    run_phase(13'd0, 100, 50, 1'b0);
    run_phase(13'd2048, 200, 55, 1'b0);
    run_phase(REG_W'($urandom_range(1, REGION_MAX_BYTES)), 250, 50, 1'b0);

    wait_for_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_alloc.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== variable_item_ring_allocator_top.f =====
hdl/vira_pkg.sv
hdl/vira_ram.sv
hdl/variable_item_ring_allocator_top.sv
hdl/vira_chk.sv
tb/sv/tb_variable_item_ring_allocator_top.sv
